// ===== hdl/bct_pkg.sv =====
`timescale 1ns / 1ps

package bct_pkg;

    // Default sizing of the block.
    localparam int NUM_BUTTONS_DEF = 16;
    localparam int COUNT_WIDTH_DEF = 16;

    // Fixed field widths of the channels.
    localparam int BTN_W   = 16;
    localparam int SRC_W   = 5;
    localparam int DUR_W   = 16;
    localparam int DIR_W   = 4;
    localparam int CFG_W   = 16;
    localparam int HAT_W   = 8;

    // First direction code that is out of range (directions are 1 to 8).
    localparam int DIR_LIMIT = 9;

    // Hat range width that marks a 4-way hat.
    localparam int FOUR_WAY_SPAN = 4;

    // Item kinds on the input channel.
    localparam logic CMD_TICK   = 1'b0;
    localparam logic CMD_REPORT = 1'b1;

    // Neutral hat direction.
    localparam logic [DIR_W-1:0] DIR_NEUTRAL = '0;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_GLITCH_MS = 2'd0,
        CFG_HAT_MIN   = 2'd1,
        CFG_HAT_MAX   = 2'd2,
        CFG_MONITOR   = 2'd3
    } cfg_index_t;

    // One input beat.
    typedef struct packed {
        logic                    command;
        logic [BTN_W-1:0]        buttons;
        logic                    hat_present;
        logic signed [HAT_W-1:0] hat_value;
    } in_item_t;

    // One result beat.
    typedef struct packed {
        logic [SRC_W-1:0] source_index;
        logic [DUR_W-1:0] duration_ms;
        logic             glitch;
        logic [DIR_W-1:0] hat_direction;
        logic             last;
    } out_item_t;

    // Map a raw hat value onto neutral or one of eight directions.
    function automatic logic [DIR_W-1:0] hat_normalize(
        input logic signed [HAT_W-1:0] v,
        input logic signed [HAT_W-1:0] mn,
        input logic signed [HAT_W-1:0] mx
    );
        logic signed [HAT_W:0]   diff;
        logic signed [HAT_W+1:0] span;
        logic [HAT_W+1:0]        n1;
        logic [DIR_W-1:0]        res;
        diff = {v[HAT_W-1], v} - {mn[HAT_W-1], mn};
        span = {{2{mx[HAT_W-1]}}, mx} - {{2{mn[HAT_W-1]}}, mn} + (HAT_W+2)'(1);
        n1   = '0;
        res  = DIR_NEUTRAL;
        if (v >= mn && v <= mx)
        begin
            // A 4-way hat uses every other direction code.
            if (span == (HAT_W+2)'(FOUR_WAY_SPAN))
                n1 = {diff, 1'b1};
            else
                n1 = {1'b0, diff} + (HAT_W+2)'(1);
            if (n1 < (HAT_W+2)'(DIR_LIMIT))
                res = n1[DIR_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== hdl/button_chatter_timer_core.sv =====
`timescale 1ns / 1ps

// A report loads its released sources into the pending mask; their result beats are then
// built in the output register. Input: one beat per cycle while in_stall is low; a report
// that releases sources stalls input until its last result beat is loaded; results leave one
// per cycle while out_stall is low. Ticks and reports update the per-source timer lanes.
// Reset (rst_n, asynchronous, active low) clears all timers, the button and hat
// history, and loads the register defaults; no clearing pass follows.
module button_chatter_timer_core #(
    parameter int NUM_BUTTONS = bct_pkg::NUM_BUTTONS_DEF,
    parameter int COUNT_WIDTH = bct_pkg::COUNT_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  bct_pkg::in_item_t          in_data,
    output logic                       out_valid,
    input  logic                       out_stall,
    output bct_pkg::out_item_t         out_data,
    input  logic                       cfg_we,
    input  bct_pkg::cfg_index_t        cfg_index,
    input  logic [bct_pkg::CFG_W-1:0]  cfg_data
);
    import bct_pkg::*;

    localparam int NSRC = NUM_BUTTONS + 1;

    // Configuration registers.
    logic [DUR_W-1:0]        glitch_ms_reg;
    logic signed [HAT_W-1:0] hat_min_reg;
    logic signed [HAT_W-1:0] hat_max_reg;
    logic                    monitor_reg;

    // History of the last report.
    logic [NUM_BUTTONS-1:0]  prev_buttons_reg, prev_buttons_next;
    logic [DIR_W-1:0]        prev_hat_reg, prev_hat_next;

    logic                    accept, tick, report;
    logic [NUM_BUTTONS-1:0]  cur_buttons, rise, fall;
    logic [DIR_W-1:0]        hat_dir_new;
    logic                    hat_change, hat_emit, hat_start;
    logic [NSRC-1:0]         lane_start, lane_stop, lane_running;
    logic [NSRC-1:0]         emit_mask;
    logic [COUNT_WIDTH-1:0]  lane_count [NSRC];
    logic                    merge_busy;

    assign in_stall = merge_busy;
    assign accept   = in_valid && !merge_busy;
    assign tick     = accept && (in_data.command == CMD_TICK);
    assign report   = accept && (in_data.command == CMD_REPORT) && monitor_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glitch_ms_reg <= DUR_W'(10);
            hat_min_reg   <= '0;
            hat_max_reg   <= HAT_W'(7);
            monitor_reg   <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GLITCH_MS: glitch_ms_reg <= cfg_data[DUR_W-1:0];
                CFG_HAT_MIN:   hat_min_reg   <= cfg_data[HAT_W-1:0];
                CFG_HAT_MAX:   hat_max_reg   <= cfg_data[HAT_W-1:0];
                CFG_MONITOR:   monitor_reg   <= cfg_data[0];
                default:       monitor_reg   <= monitor_reg;
            endcase
        end
    end

    // Report decode: button edges and hat direction changes.
    always_comb
    begin
        cur_buttons = NUM_BUTTONS'(in_data.buttons);
        rise        = cur_buttons & ~prev_buttons_reg;
        fall        = prev_buttons_reg & ~cur_buttons;
        hat_dir_new = hat_normalize(in_data.hat_value, hat_min_reg, hat_max_reg);
        hat_change  = in_data.hat_present && (hat_dir_new != prev_hat_reg);
        hat_emit    = hat_change && lane_running[NUM_BUTTONS];
        hat_start   = hat_change && (hat_dir_new != DIR_NEUTRAL);

        lane_start = {report && hat_start, {NUM_BUTTONS{report}} & rise};
        lane_stop  = {report && hat_emit,  {NUM_BUTTONS{report}} & fall};
        emit_mask  = {hat_emit, fall};

        prev_buttons_next = prev_buttons_reg;
        prev_hat_next     = prev_hat_reg;
        if (report)
        begin
            prev_buttons_next = cur_buttons;
            if (hat_change)
                prev_hat_next = hat_dir_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_buttons_reg <= '0;
            prev_hat_reg     <= DIR_NEUTRAL;
        end
        else
        begin
            prev_buttons_reg <= prev_buttons_next;
            prev_hat_reg     <= prev_hat_next;
        end
    end

    // One timer lane per button, and one for the hat.
    for (genvar g = 0; g < NSRC; g++)
    begin : g_lane
        bct_lane #(
            .COUNT_WIDTH(COUNT_WIDTH)
        ) u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .tick   (tick),
            .start  (lane_start[g]),
            .stop   (lane_stop[g]),
            .running(lane_running[g]),
            .count  (lane_count[g])
        );
    end

    // Merge the released lanes into a run of result beats.
    bct_merge #(
        .NUM_BUTTONS(NUM_BUTTONS),
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .report_load(report),
        .emit_mask  (emit_mask),
        .hat_count  (lane_count[NUM_BUTTONS]),
        .hat_dir    (prev_hat_reg),
        .lane_count (lane_count),
        .glitch_ms  (glitch_ms_reg),
        .busy       (merge_busy),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule

// ===== hdl/bct_lane.sv =====
`timescale 1ns / 1ps

module bct_lane #(
    parameter int COUNT_WIDTH = bct_pkg::COUNT_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   tick,
    input  logic                   start,
    input  logic                   stop,
    output logic                   running,
    output logic [COUNT_WIDTH-1:0] count
);

    logic                   running_reg, running_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;

    // Start clears and arms the timer; stop halts it; a tick counts a running timer up to saturation.
    always_comb
    begin
        running_next = running_reg;
        count_next   = count_reg;
        if (start)
        begin
            running_next = 1'b1;
            count_next   = '0;
        end
        else if (stop)
        begin
            running_next = 1'b0;
        end
        else if (tick && running_reg && (count_reg != '1))
        begin
            count_next = count_reg + COUNT_WIDTH'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            count_reg   <= '0;
        end
        else
        begin
            running_reg <= running_next;
            count_reg   <= count_next;
        end
    end

    assign running = running_reg;
    assign count   = count_reg;

endmodule

// ===== hdl/bct_merge.sv =====
`timescale 1ns / 1ps

module bct_merge #(
    parameter int NUM_BUTTONS = bct_pkg::NUM_BUTTONS_DEF,
    parameter int COUNT_WIDTH = bct_pkg::COUNT_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               report_load,
    input  logic [NUM_BUTTONS:0]               emit_mask,
    input  logic [COUNT_WIDTH-1:0]             hat_count,
    input  logic [bct_pkg::DIR_W-1:0]          hat_dir,
    input  logic [COUNT_WIDTH-1:0]             lane_count [NUM_BUTTONS+1],
    input  logic [bct_pkg::DUR_W-1:0]          glitch_ms,
    output logic                               busy,
    output logic                               out_valid,
    input  logic                               out_stall,
    output bct_pkg::out_item_t                 out_data
);
    import bct_pkg::*;

    localparam int NSRC  = NUM_BUTTONS + 1;
    localparam int IDX_W = $clog2(NSRC);
    localparam int CMP_W = (COUNT_WIDTH > DUR_W) ? COUNT_WIDTH : DUR_W;

    logic [NSRC-1:0]        mask_reg, mask_next;
    logic [COUNT_WIDTH-1:0] hat_cnt_reg;
    logic [DIR_W-1:0]       hat_dir_reg;
    logic                   out_valid_reg, out_valid_next;
    out_item_t              out_data_reg, out_data_next;

    logic [IDX_W-1:0]       sel;
    logic [NSRC-1:0]        sel_onehot;
    logic [NSRC-1:0]        mask_left;
    logic                   load_out;
    logic [COUNT_WIDTH-1:0] sel_count;
    logic [CMP_W-1:0]       cnt_ext;

    // Pick the next source: the hat first, then the lowest button.
    always_comb
    begin
        sel = IDX_W'(NUM_BUTTONS);
        for (int i = NUM_BUTTONS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
                sel = IDX_W'(i);
        end
        if (mask_reg[NUM_BUTTONS])
            sel = IDX_W'(NUM_BUTTONS);
        sel_onehot = NSRC'(1) << sel;
        mask_left  = mask_reg & ~sel_onehot;
    end

    // A released button lane holds its count, so it is read in place.
    always_comb
    begin
        if (sel == IDX_W'(NUM_BUTTONS))
            sel_count = hat_cnt_reg;
        else
            sel_count = lane_count[sel];
        cnt_ext = CMP_W'(sel_count);
    end

    assign load_out = (mask_reg != '0) && (!out_valid_reg || !out_stall);
    assign busy     = (mask_reg != '0) && !(load_out && (mask_left == '0));

    // Build the result beat for the selected source.
    always_comb
    begin
        out_data_next = out_data_reg;
        if (load_out)
        begin
            out_data_next.source_index = SRC_W'(sel);
            out_data_next.duration_ms  = (cnt_ext > CMP_W'({DUR_W{1'b1}})) ?
                                         {DUR_W{1'b1}} : cnt_ext[DUR_W-1:0];
            out_data_next.glitch       = (cnt_ext <= CMP_W'(glitch_ms));
            out_data_next.hat_direction = (sel == IDX_W'(NUM_BUTTONS)) ?
                                          hat_dir_reg : DIR_NEUTRAL;
            out_data_next.last         = (mask_left == '0);
        end
    end

    // Pending sources and the output register.
    always_comb
    begin
        mask_next = mask_reg;
        if (report_load)
            mask_next = emit_mask;
        else if (load_out)
            mask_next = mask_left;
        if (load_out)
            out_valid_next = 1'b1;
        else
            out_valid_next = out_valid_reg && out_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hat snapshot: the hat timer may restart in the same report.
    always_ff @(posedge clk)
    begin
        if (report_load)
        begin
            hat_cnt_reg <= hat_count;
            hat_dir_reg <= hat_dir;
        end
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
